// ===== design/lzgo_pkg.sv =====
// Package for the LZ gamma offset decompressor.
// Holds parse phases, controller states and fixed field widths; no dependencies.
package lzgo_pkg;

    localparam int GZ_W   = 5;
    localparam int LEN_W  = 17;
    localparam int OFF_W  = 12;

    localparam logic [7:0]       BUF_SENTINEL = 8'h80;
    localparam logic [GZ_W-1:0]  GZ_SAT       = 5'd16;
    localparam logic [GZ_W-1:0]  OFF_HI_BITS  = 5'd4;
    localparam logic [OFF_W-1:0] OFF_BIAS     = 12'd128;

    typedef enum logic [3:0] {
        PH_LIT,
        PH_FLAG,
        PH_ZEROS,
        PH_VALUE,
        PH_OFFBYTE,
        PH_OFFBITS,
        PH_COPY,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_CPRD,
        ST_EMIT
    } t_state;

endpackage

// ===== design/lzgo_in_if.sv =====
// Input channel of the LZ gamma offset decompressor: handshake plus item fields.
// No dependencies.
interface lzgo_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_byte;

    modport source(output valid, action, in_byte, input ready);
    modport sink(input valid, action, in_byte, output ready);
endinterface

// ===== design/lzgo_out_if.sv =====
// Output channel of the LZ gamma offset decompressor: handshake plus result fields.
// No dependencies.
interface lzgo_out_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] out_byte;
    logic       wants_byte;
    logic       finished;
    logic       misuse;

    modport source(output valid, has_byte, out_byte, wants_byte, finished, misuse,
                   input ready);
    modport sink(input valid, has_byte, out_byte, wants_byte, finished, misuse,
                 output ready);
endinterface

// ===== design/lzgo_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lzgo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== design/lz_gamma_offset_decompressor.sv =====
// Top level of the LZ gamma offset decompressor (Elias-gamma lengths, history window).
// Depends on lzgo_pkg, lzgo_in_if, lzgo_out_if and lzgo_ram.
//
//   channel  direction  fields
//   i_in     sink       action, in_byte
//   o_out    source     has_byte, out_byte, wants_byte, finished, misuse
//
// Within an item the flag parser consumes one bit per cycle, up to eight bits of a
// pushed group byte, and a match byte is written back in the cycle after its window
// RAM read. One item is in work at a time.
// Reset needs no clearing pass: a fill count marks window entries never written,
// which read as zero. A stalled output holds its result while the next item is parsed.
module lz_gamma_offset_decompressor #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzgo_in_if.sink    i_in,
    lzgo_out_if.source o_out
);

    import lzgo_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_X  = (AW+1)'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(WINDOW_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(WINDOW_DEPTH);

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [7:0]         r_buf, n_buf;
    logic               r_have, n_have;
    logic [7:0]         r_byte, n_byte;
    logic [GZ_W-1:0]    r_gz, n_gz;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [LEN_W-1:0]   r_copy, n_copy;
    logic               r_done, n_done;
    logic [AW-1:0]      r_wp, n_wp;
    logic [FW-1:0]      r_fill, n_fill;
    logic               r_has, n_has;
    logic [7:0]         r_ob, n_ob;
    logic               r_bad, n_bad;
    logic               r_out_valid, n_out_valid;
    logic               r_o_has, n_o_has;
    logic [7:0]         r_o_byte, n_o_byte;
    logic               r_o_wants, n_o_wants;
    logic               r_o_fin, n_o_fin;
    logic               r_o_bad, n_o_bad;

    logic               accept;
    logic               is_push;
    logic               slot_free;
    logic               bit_phase;
    logic               bit_avail;
    logic               bit_val;
    logic [7:0]         buf_shift;
    logic [7:0]         buf_next;
    logic [OFF_W-1:0]   copy_dist;
    logic [AW:0]        rd_sum;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;
    logic [7:0]         rd_data;
    logic               wr_en;
    logic [7:0]         wr_data;
    logic [LEN_W-1:0]   len_shift;
    logic [3:0]         off_sh;
    logic [OFF_W-1:0]   off_or;
    logic [7:0]         copy_byte;

    assign accept    = i_in.valid && (r_state == ST_IDLE);
    assign is_push   = !i_in.action;
    assign slot_free = !r_out_valid || o_out.ready;

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.has_byte   = r_o_has;
    assign o_out.out_byte   = r_o_byte;
    assign o_out.wants_byte = r_o_wants;
    assign o_out.finished   = r_o_fin;
    assign o_out.misuse     = r_o_bad;

    assign bit_phase = (r_phase == PH_FLAG) || (r_phase == PH_ZEROS) ||
                       (r_phase == PH_VALUE) || (r_phase == PH_OFFBITS);

    always_comb begin
        buf_shift = r_buf << 1;
        bit_avail = 1'b0;
        bit_val   = 1'b0;
        buf_next  = r_buf;
        if (buf_shift != 8'd0) begin
            bit_avail = 1'b1;
            bit_val   = r_buf[7];
            buf_next  = buf_shift;
        end else if (r_have) begin
            bit_avail = 1'b1;
            bit_val   = r_byte[7];
            buf_next  = {r_byte[6:0], 1'b1};
        end
    end

    assign copy_dist = r_off + OFF_W'(1);
    assign rd_sum    = {1'b0, r_wp} + DEPTH_X - (AW+1)'(copy_dist);
    assign rd_addr   = (rd_sum >= DEPTH_X) ? AW'(rd_sum - DEPTH_X) : rd_sum[AW-1:0];
    assign rd_en     = accept && !r_done && (r_phase == PH_COPY) && !is_push;

    assign copy_byte = (FW'(copy_dist) <= r_fill) ? rd_data : 8'd0;
    assign len_shift = {r_len[LEN_W-2:0], bit_val};
    assign off_sh    = 4'd6 + {1'b0, r_gz[2:0]};
    assign off_or    = r_off | (OFF_W'(bit_val) << off_sh);

    assign wr_en   = (accept && !r_done && (r_phase == PH_LIT) && is_push) ||
                     (r_state == ST_CPRD);
    assign wr_data = (r_state == ST_CPRD) ? copy_byte : i_in.in_byte;

    lzgo_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Next state of the controller.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_done || (r_phase == PH_DONE)) begin
                        n_state = ST_EMIT;
                    end else if (r_phase == PH_COPY) begin
                        n_state = is_push ? ST_EMIT : ST_CPRD;
                    end else if (!is_push) begin
                        n_state = ST_EMIT;
                    end else if (r_phase == PH_OFFBYTE) begin
                        n_state = i_in.in_byte[7] ? ST_BITS : ST_EMIT;
                    end else begin
                        n_state = ST_BITS;
                    end
                end
            end
            ST_BITS: begin
                if (!bit_phase || !bit_avail) begin
                    n_state = ST_EMIT;
                end
            end
            ST_CPRD: begin
                n_state = (r_copy == LEN_W'(1)) ? ST_BITS : ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and result updates.
    always_comb begin
        n_phase     = r_phase;
        n_buf       = r_buf;
        n_have      = r_have;
        n_byte      = r_byte;
        n_gz        = r_gz;
        n_len       = r_len;
        n_off       = r_off;
        n_copy      = r_copy;
        n_done      = r_done;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_has       = r_has;
        n_ob        = r_ob;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_has     = r_o_has;
        n_o_byte    = r_o_byte;
        n_o_wants   = r_o_wants;
        n_o_fin     = r_o_fin;
        n_o_bad     = r_o_bad;

        if (wr_en) begin
            n_wp   = (r_wp == LAST_PTR) ? '0 : r_wp + AW'(1);
            n_fill = (r_fill == FILL_MAX) ? r_fill : r_fill + FW'(1);
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_has  = 1'b0;
                    n_ob   = 8'd0;
                    n_bad  = 1'b0;
                    n_byte = i_in.in_byte;
                    n_have = 1'b0;
                    if (r_done || (r_phase == PH_DONE)) begin
                        n_bad = 1'b1;
                    end else if (r_phase == PH_COPY) begin
                        n_bad = is_push;
                    end else if (!is_push) begin
                        n_bad = 1'b1;
                    end else if (r_phase == PH_LIT) begin
                        n_has   = 1'b1;
                        n_ob    = i_in.in_byte;
                        n_phase = PH_FLAG;
                    end else if (r_phase == PH_OFFBYTE) begin
                        n_off = OFF_W'(i_in.in_byte[6:0]);
                        if (i_in.in_byte[7]) begin
                            n_gz    = OFF_HI_BITS;
                            n_phase = PH_OFFBITS;
                        end else begin
                            n_copy  = r_len + LEN_W'(1);
                            n_phase = PH_COPY;
                        end
                    end else begin
                        n_have = 1'b1;
                    end
                end
            end
            ST_BITS: begin
                if (bit_phase && bit_avail) begin
                    n_buf = buf_next;
                    if (buf_shift == 8'd0) begin
                        n_have = 1'b0;
                    end
                    case (r_phase)
                        PH_FLAG: begin
                            if (!bit_val) begin
                                n_phase = PH_LIT;
                            end else begin
                                n_gz    = '0;
                                n_len   = LEN_W'(1);
                                n_phase = PH_ZEROS;
                            end
                        end
                        PH_ZEROS: begin
                            if (!bit_val) begin
                                if (r_gz < GZ_SAT) begin
                                    n_gz = r_gz + GZ_W'(1);
                                end
                            end else begin
                                n_phase = (r_gz == '0) ? PH_OFFBYTE : PH_VALUE;
                            end
                        end
                        PH_VALUE: begin
                            n_len = len_shift;
                            if (len_shift[LEN_W-1]) begin
                                n_done  = 1'b1;
                                n_phase = PH_DONE;
                            end else begin
                                n_gz = r_gz - GZ_W'(1);
                                if (r_gz == GZ_W'(1)) begin
                                    n_phase = PH_OFFBYTE;
                                end
                            end
                        end
                        PH_OFFBITS: begin
                            n_gz = r_gz - GZ_W'(1);
                            if (r_gz == GZ_W'(1)) begin
                                n_off   = off_or + OFF_BIAS;
                                n_copy  = r_len + LEN_W'(1);
                                n_phase = PH_COPY;
                            end else begin
                                n_off = off_or;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
            ST_CPRD: begin
                n_has  = 1'b1;
                n_ob   = copy_byte;
                n_copy = r_copy - LEN_W'(1);
                if (r_copy == LEN_W'(1)) begin
                    n_phase = PH_FLAG;
                    n_have  = 1'b0;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_o_has     = r_has;
                    n_o_byte    = r_ob;
                    n_o_wants   = !(r_done || (r_phase == PH_COPY));
                    n_o_fin     = r_done;
                    n_o_bad     = r_bad;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_LIT;
            r_buf       <= BUF_SENTINEL;
            r_have      <= 1'b0;
            r_gz        <= '0;
            r_len       <= '0;
            r_off       <= '0;
            r_copy      <= '0;
            r_done      <= 1'b0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_buf       <= n_buf;
            r_have      <= n_have;
            r_gz        <= n_gz;
            r_len       <= n_len;
            r_off       <= n_off;
            r_copy      <= n_copy;
            r_done      <= n_done;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_has     <= n_has;
        r_ob      <= n_ob;
        r_bad     <= n_bad;
        r_o_has   <= n_o_has;
        r_o_byte  <= n_o_byte;
        r_o_wants <= n_o_wants;
        r_o_fin   <= n_o_fin;
        r_o_bad   <= n_o_bad;
    end

endmodule
